// File: src/ecgboc_pkg.sv
package ecgboc_pkg;

  localparam int LIST_DEPTH    = 256;
  localparam int NUM_INTERVALS = 10;
  localparam int TIME_BITS     = 24;

  localparam int ADDR_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int MEM_AW  = ADDR_W + 2;
  localparam int K_W     = $clog2(NUM_INTERVALS + 1);
  localparam int KI_W    = $clog2(NUM_INTERVALS);

  // Divider: 34-bit dividend covers (span * 1000), 13-bit divisor covers the sample rate.
  localparam int DVD_W   = TIME_BITS + 10;
  localparam int DSR_W   = 13;

  localparam int DIFF_W  = TIME_BITS + 1;
  localparam int SUM_W   = DIFF_W + K_W;
  localparam int DEV_W   = DIFF_W + 1;
  localparam int SQ_W    = 2 * DEV_W;
  localparam int SQS_W   = SQ_W + K_W;
  localparam int LIM_W   = 32;

  // The mean is taken by a reciprocal multiplication. With the rounded-up reciprocal
  // the quotient stays exact as long as the sum magnitude times NUM_INTERVALS is
  // below 2^MEAN_SHIFT, which holds for every sum of NUM_INTERVALS time differences.
  localparam int              MEAN_SHIFT = 34;
  localparam longint unsigned MEAN_RECIP =
    ((64'd1 << MEAN_SHIFT) + 64'(NUM_INTERVALS) - 64'd1) / 64'(NUM_INTERVALS);
  localparam int              MUL_W      = SUM_W + MEAN_SHIFT;

  localparam logic [1:0] SEL_END = 2'd0;
  localparam logic [1:0] SEL_ONS = 2'd1;
  localparam logic [1:0] SEL_P   = 2'd2;

  localparam logic [2:0] CMD_ADD_END   = 3'd0;
  localparam logic [2:0] CMD_ADD_ONS   = 3'd1;
  localparam logic [2:0] CMD_ADD_P     = 3'd2;
  localparam logic [2:0] CMD_CLASSIFY  = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam logic [1:0] VERDICT_SUPRA = 2'd0;
  localparam logic [1:0] VERDICT_VENT  = 2'd1;
  localparam logic [1:0] VERDICT_SKIP  = 2'd2;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_RS_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_DEV_LIMIT   = 2'd2;

endpackage

// File: src/ecgboc_mem.sv
module ecgboc_mem (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ecgboc_pkg::MEM_AW-1:0]       waddr,
  input  logic [ecgboc_pkg::TIME_BITS-1:0]    wdata,
  input  logic [ecgboc_pkg::MEM_AW-1:0]       raddr,
  output logic [ecgboc_pkg::TIME_BITS-1:0]    rdata
);

  logic [ecgboc_pkg::TIME_BITS-1:0] mem [0:(1 << ecgboc_pkg::MEM_AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ecgboc_div.sv
module ecgboc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ecgboc_pkg::DVD_W-1:0]      dividend,
  input  logic [ecgboc_pkg::DSR_W-1:0]      divisor,
  output logic                              done,
  output logic [ecgboc_pkg::DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(ecgboc_pkg::DVD_W + 1);

  logic [ecgboc_pkg::DSR_W:0]    rem_r;
  logic [ecgboc_pkg::DVD_W-1:0]  quo_r;
  logic [ecgboc_pkg::DSR_W-1:0]  dsr_r;
  logic [CW-1:0]                 cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ecgboc_pkg::DSR_W:0]    sh;
  logic                          fits;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign sh   = {rem_r[ecgboc_pkg::DSR_W-1:0], quo_r[ecgboc_pkg::DVD_W-1]};
  assign fits = sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ecgboc_pkg::DVD_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? (sh - {1'b0, dsr_r}) : sh;
        quo_r <= {quo_r[ecgboc_pkg::DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/ecg_beat_origin_classifier.sv
// ECG beat origin classifier.
// Input channel (in_valid/in_stall): a request carries a command and a sample time.
// Append commands store a fiducial time in one of three lists (QRS end, QRS onset,
// P onset) and clear empties all three; these give no result.
// A classify request scans the QRS-end list for the first entry after the peak,
// converts the span to ms with a one-bit-per-cycle divider (34 steps), and if the
// interval is below the limit, scans both onset lists and gathers ten onset-minus-P
// differences whose mean and variance decide the verdict.
// All lists share one synchronous RAM with a single read port, so a classify reads
// one list entry at a time: each scanned entry passes a read and a check state, each
// interval pair passes S_PAIR_Q, S_PAIR_P and S_PAIR_D, and each squared deviation
// passes S_DEV, S_SQ and S_ACC; the span conversion waits for one divider pass.
// Exactly one result (out_valid/out_stall) is produced per classify request.
// The finished result sits in an output register; the next request is taken while it
// waits, and a later result holds until the receiver releases the stall.
// Reset empties the lists and restores the register defaults; no clearing pass is run.
module ecg_beat_origin_classifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_command,
  input  logic [23:0]                          in_event_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_verdict,
  output logic [23:0]                          out_peak_time,
  output logic [15:0]                          out_rs_interval_ms,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [15:0]                          cfg_wdata
);

  localparam int TB = ecgboc_pkg::TIME_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_E_RD, S_E_CHK, S_MUL, S_DIV_MS, S_CMP,
    S_Q_RD, S_Q_CHK, S_P_RD, S_P_CHK,
    S_PAIR_Q, S_PAIR_P, S_PAIR_D, S_MEAN, S_DIV_MEAN,
    S_DEV, S_SQ, S_ACC, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  logic [12:0] sr_r;
  logic [15:0] rs_lim_r;
  logic [15:0] dev_lim_r;

  logic [ecgboc_pkg::CNT_W-1:0] end_cnt_r, ons_cnt_r, p_cnt_r;
  logic [ecgboc_pkg::CNT_W-1:0] idx_r, qi_r, pi_r;
  logic [ecgboc_pkg::K_W-1:0]   k_r;

  logic [TB-1:0]                     r_r;
  logic [TB-1:0]                     span_r;
  logic [TB-1:0]                     onset_r;
  logic [15:0]                       ms_r;
  logic [1:0]                        verdict_r;
  logic signed [ecgboc_pkg::DIFF_W-1:0] diffs_r [0:ecgboc_pkg::NUM_INTERVALS-1];
  logic signed [ecgboc_pkg::SUM_W-1:0]  sum_r;
  logic [ecgboc_pkg::MUL_W-1:0]      mprod_r;
  logic signed [ecgboc_pkg::DIFF_W-1:0] mean_r;
  logic [ecgboc_pkg::DEV_W-1:0]      mag_r;
  logic [ecgboc_pkg::SQ_W-1:0]       sq_r;
  logic [ecgboc_pkg::SQS_W-1:0]      sqsum_r;
  logic [ecgboc_pkg::LIM_W-1:0]      lim_r;

  logic                              out_valid_r;
  logic [1:0]                        out_verdict_r;
  logic [23:0]                       out_peak_r;
  logic [15:0]                       out_ms_r;

  logic                              accept;
  logic [TB-1:0]                     t_in;
  logic                              mem_we;
  logic [ecgboc_pkg::MEM_AW-1:0]     mem_waddr, mem_raddr;
  logic [TB-1:0]                     mem_rdata;
  logic [ecgboc_pkg::CNT_W-1:0]      app_cnt;
  logic                              div_start, div_done;
  logic [ecgboc_pkg::DVD_W-1:0]      div_dvd, div_q;
  logic [ecgboc_pkg::DSR_W-1:0]      div_dsr;
  logic [ecgboc_pkg::SUM_W-1:0]      sum_mag;
  logic signed [ecgboc_pkg::DEV_W-1:0] dev;
  logic [ecgboc_pkg::SQS_W:0]        lim10;
  logic                              out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign t_in     = in_event_time[TB-1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (in_command)
      ecgboc_pkg::CMD_ADD_END: app_cnt = end_cnt_r;
      ecgboc_pkg::CMD_ADD_ONS: app_cnt = ons_cnt_r;
      default:                 app_cnt = p_cnt_r;
    endcase
  end

  assign mem_we = accept && (in_command == ecgboc_pkg::CMD_ADD_END ||
                             in_command == ecgboc_pkg::CMD_ADD_ONS ||
                             in_command == ecgboc_pkg::CMD_ADD_P) &&
                  app_cnt < ecgboc_pkg::CNT_W'(ecgboc_pkg::LIST_DEPTH);
  assign mem_waddr = {in_command[1:0], app_cnt[ecgboc_pkg::ADDR_W-1:0]};

  always_comb begin
    case (state_r)
      S_E_RD:   mem_raddr = {ecgboc_pkg::SEL_END, idx_r[ecgboc_pkg::ADDR_W-1:0]};
      S_Q_RD:   mem_raddr = {ecgboc_pkg::SEL_ONS, idx_r[ecgboc_pkg::ADDR_W-1:0]};
      S_P_RD:   mem_raddr = {ecgboc_pkg::SEL_P,   idx_r[ecgboc_pkg::ADDR_W-1:0]};
      S_PAIR_Q: mem_raddr = {ecgboc_pkg::SEL_ONS, qi_r[ecgboc_pkg::ADDR_W-1:0]};
      S_PAIR_P: mem_raddr = {ecgboc_pkg::SEL_P,   pi_r[ecgboc_pkg::ADDR_W-1:0]};
      default:  mem_raddr = '0;
    endcase
  end

  ecgboc_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (t_in),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign sum_mag   = sum_r[ecgboc_pkg::SUM_W-1] ? ecgboc_pkg::SUM_W'(-sum_r)
                                                 : ecgboc_pkg::SUM_W'(sum_r);
  assign div_start = state_r == S_MUL && sr_r != '0;
  assign div_dvd   = ecgboc_pkg::DVD_W'(span_r) * ecgboc_pkg::DVD_W'(1000);
  assign div_dsr   = sr_r;

  ecgboc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign dev = ecgboc_pkg::DEV_W'(diffs_r[k_r[ecgboc_pkg::KI_W-1:0]])
             - ecgboc_pkg::DEV_W'(mean_r);
  // floor(s / N) >= L*L is the same test as s >= N*L*L for integers.
  assign lim10 = (ecgboc_pkg::SQS_W+1)'(lim_r)
               * (ecgboc_pkg::SQS_W+1)'(ecgboc_pkg::NUM_INTERVALS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sr_r        <= 13'd360;
      rs_lim_r    <= 16'd360;
      dev_lim_r   <= 16'd1000;
      end_cnt_r   <= '0;
      ons_cnt_r   <= '0;
      p_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loaded in S_OUT takes the place of the one leaving.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ecgboc_pkg::CFG_SAMPLE_RATE: sr_r      <= cfg_wdata[12:0];
          ecgboc_pkg::CFG_RS_LIMIT:    rs_lim_r  <= cfg_wdata;
          ecgboc_pkg::CFG_DEV_LIMIT:   dev_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (mem_we) begin
              case (in_command)
                ecgboc_pkg::CMD_ADD_END: end_cnt_r <= end_cnt_r + 1'b1;
                ecgboc_pkg::CMD_ADD_ONS: ons_cnt_r <= ons_cnt_r + 1'b1;
                default:                 p_cnt_r   <= p_cnt_r + 1'b1;
              endcase
            end
            if (in_command == ecgboc_pkg::CMD_CLEAR) begin
              end_cnt_r <= '0;
              ons_cnt_r <= '0;
              p_cnt_r   <= '0;
            end
            if (in_command == ecgboc_pkg::CMD_CLASSIFY) begin
              r_r     <= t_in;
              idx_r   <= '0;
              state_r <= S_E_RD;
            end
          end
        end
        S_E_RD: begin
          if (idx_r >= end_cnt_r) begin
            verdict_r <= ecgboc_pkg::VERDICT_SKIP;
            ms_r      <= '0;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_E_CHK;
          end
        end
        S_E_CHK: begin
          if (mem_rdata > r_r) begin
            span_r  <= mem_rdata - r_r;
            state_r <= S_MUL;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_E_RD;
          end
        end
        S_MUL: begin
          if (sr_r == '0) begin
            ms_r    <= 16'hFFFF;
            state_r <= S_CMP;
          end else begin
            state_r <= S_DIV_MS;
          end
        end
        S_DIV_MS: begin
          if (div_done) begin
            ms_r    <= (div_q > ecgboc_pkg::DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          lim_r <= ecgboc_pkg::LIM_W'(dev_lim_r) * ecgboc_pkg::LIM_W'(dev_lim_r);
          if (ms_r >= rs_lim_r) begin
            verdict_r <= ecgboc_pkg::VERDICT_VENT;
            state_r   <= S_OUT;
          end else begin
            idx_r   <= '0;
            state_r <= S_Q_RD;
          end
        end
        S_Q_RD: begin
          if (idx_r >= ons_cnt_r) begin
            verdict_r <= ecgboc_pkg::VERDICT_SUPRA;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_Q_CHK;
          end
        end
        S_Q_CHK: begin
          if (mem_rdata > r_r) begin
            qi_r    <= idx_r;
            idx_r   <= '0;
            state_r <= S_P_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_Q_RD;
          end
        end
        S_P_RD: begin
          if (idx_r >= p_cnt_r) begin
            verdict_r <= ecgboc_pkg::VERDICT_SUPRA;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_P_CHK;
          end
        end
        S_P_CHK: begin
          if (mem_rdata > r_r) begin
            pi_r    <= idx_r;
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_PAIR_Q;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_P_RD;
          end
        end
        S_PAIR_Q: begin
          if (qi_r >= ons_cnt_r || pi_r >= p_cnt_r) begin
            verdict_r <= ecgboc_pkg::VERDICT_SUPRA;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_PAIR_P;
          end
        end
        S_PAIR_P: begin
          onset_r <= mem_rdata;
          state_r <= S_PAIR_D;
        end
        S_PAIR_D: begin
          diffs_r[k_r[ecgboc_pkg::KI_W-1:0]] <=
            $signed({1'b0, onset_r}) - $signed({1'b0, mem_rdata});
          sum_r <= sum_r + ecgboc_pkg::SUM_W'($signed({1'b0, onset_r})
                                            - $signed({1'b0, mem_rdata}));
          qi_r  <= qi_r + 1'b1;
          pi_r  <= pi_r + 1'b1;
          if (k_r == ecgboc_pkg::K_W'(ecgboc_pkg::NUM_INTERVALS - 1)) begin
            state_r <= S_MEAN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PAIR_Q;
          end
        end
        S_MEAN: begin
          mprod_r <= ecgboc_pkg::MUL_W'(sum_mag)
                   * ecgboc_pkg::MUL_W'(ecgboc_pkg::MEAN_RECIP);
          state_r <= S_DIV_MEAN;
        end
        S_DIV_MEAN: begin
          mean_r  <= sum_r[ecgboc_pkg::SUM_W-1]
                   ? -$signed(mprod_r[ecgboc_pkg::MEAN_SHIFT +: ecgboc_pkg::DIFF_W])
                   : $signed(mprod_r[ecgboc_pkg::MEAN_SHIFT +: ecgboc_pkg::DIFF_W]);
          k_r     <= '0;
          sqsum_r <= '0;
          state_r <= S_DEV;
        end
        S_DEV: begin
          mag_r   <= dev[ecgboc_pkg::DEV_W-1] ? ecgboc_pkg::DEV_W'(-dev)
                                              : ecgboc_pkg::DEV_W'(dev);
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= ecgboc_pkg::SQ_W'(mag_r) * ecgboc_pkg::SQ_W'(mag_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sqsum_r <= sqsum_r + ecgboc_pkg::SQS_W'(sq_r);
          if (k_r == ecgboc_pkg::K_W'(ecgboc_pkg::NUM_INTERVALS - 1)) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_DEV;
          end
        end
        S_FIN: begin
          verdict_r <= ({1'b0, sqsum_r} >= lim10) ? ecgboc_pkg::VERDICT_VENT
                                                  : ecgboc_pkg::VERDICT_SUPRA;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= verdict_r;
            out_peak_r    <= 24'(r_r);
            out_ms_r      <= ms_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_verdict_r;
  assign out_peak_time      = out_peak_r;
  assign out_rs_interval_ms = out_ms_r;

endmodule

// File: src/ecgboc_checker.sv
module ecgboc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_verdict,
  input logic [23:0] out_peak_time,
  input logic [15:0] out_rs_interval_ms
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_time)
                               && $stable(out_verdict))
    else $error("stalled result changed");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict == ecgboc_pkg::VERDICT_SUPRA ||
                  out_verdict == ecgboc_pkg::VERDICT_VENT ||
                  out_verdict == ecgboc_pkg::VERDICT_SKIP)
    else $error("unknown verdict code");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == ecgboc_pkg::VERDICT_SKIP |-> out_rs_interval_ms == 16'd0)
    else $error("skipped beat carries an interval");

  a_list_cmd_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command != ecgboc_pkg::CMD_CLASSIFY |=> !in_stall)
    else $error("list request did not finish in one cycle");

endmodule

bind ecg_beat_origin_classifier ecgboc_checker u_ecgboc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_command         (in_command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_verdict        (out_verdict),
  .out_peak_time      (out_peak_time),
  .out_rs_interval_ms (out_rs_interval_ms)
);
